FILE: hw/rtl/mbag_pkg.sv
// ---------------------------------------------------------------------------
// mbag_pkg
// Shared types and constants of the mean-based auto gamma core.
// ---------------------------------------------------------------------------
package mbag_pkg;

    localparam int MAX_PIXELS_LOG2 = 22;
    localparam int CNT_W           = MAX_PIXELS_LOG2 + 1;
    localparam int SUM_W           = MAX_PIXELS_LOG2 + 8;
    localparam int NORM_W          = (SUM_W > 31) ? SUM_W : 31;
    localparam int SHIFT_W         = $clog2(NORM_W);
    localparam int LOG_FRAC_W      = 30;
    localparam int LOG_W           = SHIFT_W + LOG_FRAC_W;

    localparam int PIX_W           = 8;
    localparam int TARGET_W        = 12;
    localparam logic [TARGET_W-1:0] TARGET_RESET = 12'd1434;

    localparam int GAMMA_W         = 16;
    localparam int GAMMA_FRAC_W    = 12;
    localparam logic [GAMMA_W-1:0] GAMMA_MAX = 16'hFFFF;
    localparam int A_W             = 34;
    localparam int DIV_W           = A_W + GAMMA_FRAC_W + 1;

    localparam int FIX_W           = 32;
    localparam int LUT_DEPTH       = 256;
    localparam int LUT_ADDR_W      = $clog2(LUT_DEPTH);

    localparam int Q_DEPTH         = 4;
    localparam int Q_IDX_W         = $clog2(Q_DEPTH);

    localparam logic KIND_MEASURE  = 1'b0;
    localparam logic KIND_CORRECT  = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] in_blue;
        logic [PIX_W-1:0] in_green;
        logic [PIX_W-1:0] in_red;
        logic             is_last;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] out_blue;
        logic [PIX_W-1:0] out_green;
        logic [PIX_W-1:0] out_red;
        logic             out_last;
    } out_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
        logic             last;
    } pix_t;

    typedef struct packed {
        logic                  we;
        logic [LUT_ADDR_W-1:0] addr;
        logic [PIX_W-1:0]      data;
    } lut_wr_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } solve_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic gamma_zero;
    } solve_stat_t;

endpackage

FILE: hw/rtl/mbag_ram.sv
// ---------------------------------------------------------------------------
// mbag_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module mbag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/mbag_fifo.sv
// ---------------------------------------------------------------------------
// mbag_fifo
// Short queue of correct pixels between the front and the back.
// ---------------------------------------------------------------------------
module mbag_fifo
    import mbag_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  pix_t push_data,
    input  logic pop,
    output pix_t head,
    output logic empty,
    output logic full
);

    pix_t               mem_reg [Q_DEPTH];
    logic [Q_IDX_W-1:0] wr_ptr_reg;
    logic [Q_IDX_W-1:0] rd_ptr_reg;
    logic [Q_IDX_W:0]   cnt_reg;

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == (Q_IDX_W + 1)'(Q_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/mbag_front.sv
// ---------------------------------------------------------------------------
// mbag_front
// Accepts beats, accumulates gray statistics and hands the end of a
// measure pass to the solver.
// ---------------------------------------------------------------------------
module mbag_front
    import mbag_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  in_item_t    item,
    output logic        busy,
    input  logic        drained,
    input  logic        q_full,
    output logic        push,
    output pix_t        push_data,
    output solve_req_t  req,
    input  solve_stat_t stat
);

    typedef enum logic [2:0] {
        F_RUN   = 3'b001,
        F_DRAIN = 3'b010,
        F_SOLVE = 3'b100
    } front_state_t;

    front_state_t     state_reg;
    logic             mv_reg;
    logic             ml_reg;
    logic [PIX_W-1:0] gray_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] count_reg;
    logic             accept;
    logic [22:0]      gray_full;

    assign busy   = (state_reg != F_RUN) || (mv_reg && ml_reg) || q_full;
    assign accept = start && !busy;
    assign push   = accept && (item.kind == KIND_CORRECT);

    assign push_data.blue  = item.in_blue;
    assign push_data.green = item.in_green;
    assign push_data.red   = item.in_red;
    assign push_data.last  = item.is_last;

    assign req.start = (state_reg == F_DRAIN) && drained;
    assign req.sum   = sum_reg;
    assign req.count = count_reg;

    assign gray_full = 23'd1868 * {15'd0, item.in_blue}
                     + 23'd9617 * {15'd0, item.in_green}
                     + 23'd4899 * {15'd0, item.in_red}
                     + 23'd8192;

    always_ff @(posedge clk)
    begin
        gray_reg <= gray_full[21:14];
        ml_reg   <= item.is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_RUN;
            mv_reg    <= 1'b0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            mv_reg <= accept && (item.kind == KIND_MEASURE);
            // Once the count reaches its limit, further pixels are left out.
            if (mv_reg && !count_reg[CNT_W-1])
            begin
                sum_reg   <= sum_reg + SUM_W'(gray_reg);
                count_reg <= count_reg + 1'b1;
            end
            unique case (state_reg)
                F_RUN:
                begin
                    if (mv_reg && ml_reg)
                    begin
                        state_reg <= F_DRAIN;
                    end
                end
                F_DRAIN:
                begin
                    if (drained)
                    begin
                        sum_reg   <= '0;
                        count_reg <= '0;
                        state_reg <= F_SOLVE;
                    end
                end
                F_SOLVE:
                begin
                    if (stat.done)
                    begin
                        state_reg <= F_RUN;
                    end
                end
                default:
                begin
                    state_reg <= F_RUN;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/mbag_solve.sv
// ---------------------------------------------------------------------------
// mbag_solve
// Works out gamma from the pass statistics with a shared log2 unit and a
// restoring divider, then fills the tone table one code at a time unless gamma is zero.
// ---------------------------------------------------------------------------
module mbag_solve
    import mbag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  solve_req_t          req,
    input  logic [TARGET_W-1:0] target_level,
    output solve_stat_t         stat,
    output lut_wr_t             lut_wr
);

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_CHECK    = 12'b0000_0000_0010,
        S_LOG_NORM = 12'b0000_0000_0100,
        S_LOG_ITER = 12'b0000_0000_1000,
        S_PREP     = 12'b0000_0001_0000,
        S_DIV      = 12'b0000_0010_0000,
        S_SAT      = 12'b0000_0100_0000,
        S_PX_INIT  = 12'b0000_1000_0000,
        S_PX_POW   = 12'b0001_0000_0000,
        S_SQRT     = 12'b0010_0000_0000,
        S_SQ_MUL   = 12'b0100_0000_0000,
        S_PX_WRITE = 12'b1000_0000_0000
    } solve_state_t;

    localparam logic [1:0] SEL_TARGET = 2'd0;
    localparam logic [1:0] SEL_DENOM  = 2'd1;
    localparam logic [1:0] SEL_SUM    = 2'd2;

    localparam int SQ_W  = 64;
    localparam int DCNT_W = $clog2(DIV_W);
    localparam logic [A_W-1:0]   LOG2_4096 = A_W'(64'd12 << LOG_FRAC_W);
    localparam logic [FIX_W-1:0] FIX_ONE   = FIX_W'(64'd1 << 31);
    localparam logic [FIX_W-1:0] X_STEP    = FIX_W'(32'd8421504);

    solve_state_t        state_reg;
    logic                done_reg;
    logic [GAMMA_W-1:0]  gamma_reg;
    logic [1:0]          sel_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SUM_W-1:0]    denom_reg;
    logic                zero_reg;

    logic [NORM_W-1:0]   norm_reg;
    logic [SHIFT_W-1:0]  sh_reg;
    logic [30:0]         y_reg;
    logic [4:0]          it_reg;
    logic [29:0]         frac_reg;
    logic [LOG_W-1:0]    la_reg;
    logic [LOG_W-1:0]    lnum_reg;
    logic [LOG_W-1:0]    lb_reg;

    logic [DIV_W-1:0]    dvd_reg;
    logic [LOG_W-1:0]    dsr_reg;
    logic [LOG_W-1:0]    rem_reg;
    logic [DCNT_W-1:0]   dcnt_reg;

    logic [LUT_ADDR_W-1:0] c_reg;
    logic [FIX_W-1:0]    xq_reg;
    logic [PIX_W-1:0]    xr_reg;
    logic [FIX_W-1:0]    x_reg;
    logic [FIX_W-1:0]    r_reg;
    logic [FIX_W-1:0]    s_reg;
    logic [3:0]          k_reg;
    logic [3:0]          j_reg;
    logic [SQ_W-1:0]     v_reg;
    logic [SQ_W-1:0]     res_reg;
    logic [SQ_W-1:0]     bit_reg;

    logic [TARGET_W-1:0] t_eff;
    logic [61:0]         ysq;
    logic [31:0]         yy;
    logic [29:0]         frac_next;
    logic [LOG_W-1:0]    log_res;
    logic [LOG_W-1:0]    bdiff;
    logic [A_W-1:0]      a_val;
    logic [LOG_W:0]      rem_sh;
    logic                rem_ge;
    logic [63:0]         rx_prod;
    logic [63:0]         rs_prod;
    logic [SQ_W-1:0]     trial;
    logic                sq_ge;
    logic [SQ_W-1:0]     v_next;
    logic [SQ_W-1:0]     res_next;
    logic [39:0]         o_prod;
    logic [8:0]          o_raw;
    logic [PIX_W-1:0]    o_val;
    logic [8:0]          xr_sum;
    logic [FIX_W-1:0]    x_cur;
    logic [NORM_W-1:0]   next_operand;

    assign stat.busy       = (state_reg != S_IDLE);
    assign stat.done       = done_reg;
    assign stat.gamma_zero = (gamma_reg == '0);

    assign lut_wr.we   = (state_reg == S_PX_WRITE);
    assign lut_wr.addr = c_reg;
    assign lut_wr.data = o_val;

    always_comb
    begin
        t_eff     = (target_level == '0) ? TARGET_W'(1) : target_level;
        ysq       = 62'(y_reg) * 62'(y_reg);
        yy        = ysq[61:30];
        frac_next = frac_reg | (yy[31] ? (30'd1 << it_reg) : 30'd0);
        log_res   = {SHIFT_W'(NORM_W - 1) - sh_reg, frac_next};
        bdiff     = lnum_reg - lb_reg;
        a_val     = LOG2_4096 - A_W'(la_reg);
        rem_sh    = {rem_reg, dvd_reg[DIV_W-1]};
        rem_ge    = (rem_sh >= {1'b0, dsr_reg});
        rx_prod   = 64'(r_reg) * 64'(x_reg);
        rs_prod   = 64'(r_reg) * 64'(s_reg);
        trial     = res_reg + bit_reg;
        sq_ge     = (v_reg >= trial);
        v_next    = sq_ge ? (v_reg - trial) : v_reg;
        res_next  = sq_ge ? ((res_reg >> 1) + bit_reg) : (res_reg >> 1);
        o_prod    = 40'(r_reg) * 40'd255;
        o_raw     = o_prod[39:31];
        o_val     = (o_raw > 9'd255) ? 8'd255 : o_raw[PIX_W-1:0];
        xr_sum    = {1'b0, xr_reg} + 9'd128;
        x_cur     = xq_reg + FIX_W'(xr_reg != '0);
        case (sel_reg)
            SEL_TARGET: next_operand = NORM_W'(denom_reg);
            default:    next_operand = NORM_W'(sum_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                sum_reg   <= req.sum;
                denom_reg <= SUM_W'(req.count) * SUM_W'(255);
                zero_reg  <= (req.count == '0) || (req.sum == '0);
                sel_reg   <= SEL_TARGET;
                norm_reg  <= NORM_W'(t_eff);
                sh_reg    <= '0;
                c_reg     <= '0;
                xq_reg    <= '0;
                xr_reg    <= '0;
            end
            S_LOG_NORM:
            begin
                if (norm_reg[NORM_W-1])
                begin
                    y_reg    <= norm_reg[NORM_W-1 -: 31];
                    it_reg   <= 5'd29;
                    frac_reg <= '0;
                end
                else
                begin
                    norm_reg <= norm_reg << 1;
                    sh_reg   <= sh_reg + 1'b1;
                end
            end
            S_LOG_ITER:
            begin
                y_reg    <= yy[31] ? yy[31:1] : yy[30:0];
                frac_reg <= frac_next;
                it_reg   <= it_reg - 1'b1;
                if (it_reg == '0)
                begin
                    case (sel_reg)
                        SEL_TARGET: la_reg   <= log_res;
                        SEL_DENOM:  lnum_reg <= log_res;
                        default:    lb_reg   <= log_res;
                    endcase
                    norm_reg <= next_operand;
                    sh_reg   <= '0;
                    sel_reg  <= sel_reg + 1'b1;
                end
            end
            S_PREP:
            begin
                dvd_reg  <= DIV_W'({a_val, {GAMMA_FRAC_W{1'b0}}}) + DIV_W'(bdiff >> 1);
                dsr_reg  <= bdiff;
                rem_reg  <= '0;
                dcnt_reg <= DCNT_W'(DIV_W - 1);
            end
            S_DIV:
            begin
                rem_reg  <= rem_ge ? LOG_W'(rem_sh - {1'b0, dsr_reg}) : LOG_W'(rem_sh);
                dvd_reg  <= {dvd_reg[DIV_W-2:0], rem_ge};
                dcnt_reg <= dcnt_reg - 1'b1;
            end
            S_PX_INIT:
            begin
                x_reg <= x_cur;
                s_reg <= x_cur;
                r_reg <= FIX_ONE;
                k_reg <= gamma_reg[GAMMA_W-1:GAMMA_FRAC_W];
                j_reg <= 4'd11;
            end
            S_PX_POW:
            begin
                if (k_reg != '0)
                begin
                    r_reg <= rx_prod[62:31];
                    k_reg <= k_reg - 1'b1;
                end
                else
                begin
                    v_reg   <= {1'b0, s_reg, 31'd0};
                    res_reg <= '0;
                    bit_reg <= SQ_W'(64'd1 << 62);
                end
            end
            S_SQRT:
            begin
                v_reg   <= v_next;
                res_reg <= res_next;
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0])
                begin
                    s_reg <= res_next[FIX_W-1:0];
                end
            end
            S_SQ_MUL:
            begin
                if (gamma_reg[j_reg])
                begin
                    r_reg <= rs_prod[62:31];
                end
                j_reg   <= j_reg - 1'b1;
                v_reg   <= {1'b0, s_reg, 31'd0};
                res_reg <= '0;
                bit_reg <= SQ_W'(64'd1 << 62);
            end
            S_PX_WRITE:
            begin
                c_reg <= c_reg + 1'b1;
                // x steps by 2^31/255 per code: quotient and remainder kept apart.
                if (xr_sum >= 9'd255)
                begin
                    xr_reg <= PIX_W'(xr_sum - 9'd255);
                    xq_reg <= xq_reg + X_STEP + FIX_W'(1);
                end
                else
                begin
                    xr_reg <= xr_sum[PIX_W-1:0];
                    xq_reg <= xq_reg + X_STEP;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            gamma_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (zero_reg)
                    begin
                        gamma_reg <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else if (sum_reg >= denom_reg)
                    begin
                        gamma_reg <= GAMMA_MAX;
                        state_reg <= S_PX_INIT;
                    end
                    else
                    begin
                        state_reg <= S_LOG_NORM;
                    end
                end
                S_LOG_NORM:
                begin
                    if (norm_reg[NORM_W-1])
                    begin
                        state_reg <= S_LOG_ITER;
                    end
                end
                S_LOG_ITER:
                begin
                    if (it_reg == '0)
                    begin
                        state_reg <= (sel_reg == SEL_SUM) ? S_PREP : S_LOG_NORM;
                    end
                end
                S_PREP:
                begin
                    if (lnum_reg <= lb_reg)
                    begin
                        gamma_reg <= GAMMA_MAX;
                        state_reg <= S_PX_INIT;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (dcnt_reg == '0)
                    begin
                        state_reg <= S_SAT;
                    end
                end
                S_SAT:
                begin
                    if (|dvd_reg[DIV_W-1:GAMMA_W])
                    begin
                        gamma_reg <= GAMMA_MAX;
                        state_reg <= S_PX_INIT;
                    end
                    else if (dvd_reg[GAMMA_W-1:0] == '0)
                    begin
                        // A gamma of zero needs no table: the back forces 255.
                        gamma_reg <= '0;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        gamma_reg <= dvd_reg[GAMMA_W-1:0];
                        state_reg <= S_PX_INIT;
                    end
                end
                S_PX_INIT:
                begin
                    state_reg <= S_PX_POW;
                end
                S_PX_POW:
                begin
                    if (k_reg == '0)
                    begin
                        state_reg <= S_SQRT;
                    end
                end
                S_SQRT:
                begin
                    if (bit_reg[0])
                    begin
                        state_reg <= S_SQ_MUL;
                    end
                end
                S_SQ_MUL:
                begin
                    state_reg <= (j_reg == '0) ? S_PX_WRITE : S_SQRT;
                end
                S_PX_WRITE:
                begin
                    if (c_reg == LUT_ADDR_W'(LUT_DEPTH - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_PX_INIT;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/mbag_back.sv
// ---------------------------------------------------------------------------
// mbag_back
// Drains the pixel queue through three copies of the tone table and
// registers the corrected beat.
// ---------------------------------------------------------------------------
module mbag_back
    import mbag_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_empty,
    input  pix_t      q_head,
    output logic      pop,
    input  lut_wr_t   lut_wr,
    input  logic      gamma_zero,
    output logic      idle,
    output out_item_t result,
    output logic      result_strobe
);

    logic             v1_reg;
    logic             last1_reg;
    logic             bypass1_reg;
    logic             strobe_reg;
    out_item_t        result_reg;
    logic [PIX_W-1:0] blue_q;
    logic [PIX_W-1:0] green_q;
    logic [PIX_W-1:0] red_q;

    assign pop           = !q_empty;
    assign idle          = !v1_reg;
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    mbag_ram #(.WIDTH(PIX_W), .DEPTH(LUT_DEPTH)) u_lut_blue (
        .clk   (clk),
        .we    (lut_wr.we),
        .waddr (lut_wr.addr),
        .wdata (lut_wr.data),
        .raddr (q_head.blue),
        .rdata (blue_q)
    );

    mbag_ram #(.WIDTH(PIX_W), .DEPTH(LUT_DEPTH)) u_lut_green (
        .clk   (clk),
        .we    (lut_wr.we),
        .waddr (lut_wr.addr),
        .wdata (lut_wr.data),
        .raddr (q_head.green),
        .rdata (green_q)
    );

    mbag_ram #(.WIDTH(PIX_W), .DEPTH(LUT_DEPTH)) u_lut_red (
        .clk   (clk),
        .we    (lut_wr.we),
        .waddr (lut_wr.addr),
        .wdata (lut_wr.data),
        .raddr (q_head.red),
        .rdata (red_q)
    );

    always_ff @(posedge clk)
    begin
        last1_reg   <= q_head.last;
        bypass1_reg <= gamma_zero;
        // With gamma zero every code, zero included, maps to full scale.
        result_reg.out_blue  <= bypass1_reg ? 8'd255 : blue_q;
        result_reg.out_green <= bypass1_reg ? 8'd255 : green_q;
        result_reg.out_red   <= bypass1_reg ? 8'd255 : red_q;
        result_reg.out_last  <= last1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg     <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            v1_reg     <= pop;
            strobe_reg <= v1_reg;
        end
    end

endmodule

FILE: hw/rtl/mean_based_auto_gamma_core.sv
// ---------------------------------------------------------------------------
// mean_based_auto_gamma_core
// Two-pass automatic gamma correction of a BGR pixel stream.
// ---------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  input     start, busy, item              beat taken when start && !busy
//  result    result_strobe, result          one-cycle strobe, cannot stall
//  config    target_level_we, target_level  written when target_level_we
//
// A correct beat is taken every cycle while busy is low (a full queue raises
// busy), and its result strobes after the queue, the table read and the
// result register; measure beats give no result. The last measure beat
// holds busy while the queue drains, three log2 runs, a bit-serial divide
// and the fill of all 256 codes, which uses a bit-serial square root. A gamma
// of zero skips the fill. Reset needs no clearing pass.
// ---------------------------------------------------------------------------
module mean_based_auto_gamma_core
    import mbag_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  in_item_t            item,
    output logic                result_strobe,
    output out_item_t           result,
    input  logic                target_level_we,
    input  logic [TARGET_W-1:0] target_level
);

    logic [TARGET_W-1:0] target_reg;
    logic                q_push;
    pix_t                q_data;
    logic                q_pop;
    pix_t                q_head;
    logic                q_empty;
    logic                q_full;
    logic                back_idle;
    lut_wr_t             lut_wr;
    solve_req_t          req;
    solve_stat_t         stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= TARGET_RESET;
        end
        else if (target_level_we)
        begin
            target_reg <= target_level;
        end
    end

    mbag_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .drained   (q_empty && back_idle),
        .q_full    (q_full),
        .push      (q_push),
        .push_data (q_data),
        .req       (req),
        .stat      (stat)
    );

    mbag_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    mbag_solve u_solve (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .target_level (target_reg),
        .stat         (stat),
        .lut_wr       (lut_wr)
    );

    mbag_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .pop           (q_pop),
        .lut_wr        (lut_wr),
        .gamma_zero    (stat.gamma_zero),
        .idle          (back_idle),
        .result        (result),
        .result_strobe (result_strobe)
    );

    // The table is rewritten only while no pixel is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        lut_wr.we |-> (q_empty && back_idle))
        else $error("tone table written while pixels are in flight");

    assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> !q_push)
        else $error("pixel queued while gamma is being solved");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind == KIND_MEASURE && item.is_last) |=> busy)
        else $error("end of measure pass did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(q_pop, 2))
        else $error("result strobe without a queued pixel");

endmodule
